// ===== rtl/assert_macros.svh =====
// Assertion macros for the arrive steering RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`endif
`ifndef NO_ASSERTIONS
`define ASSERT_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("forbidden condition");
`else
`define ASSERT_NEVER(lbl, clk, rst_n, prop)
`endif
`endif

// ===== rtl/asf_pkg.sv =====
// Shared constants, payload type and helpers for the arrive steering pipeline.
// No dependencies.
package asf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int VW   = 32;                  // coordinate / velocity width
  localparam int OW   = VW + 1;              // offset width
  localparam int RADW = 2 * OW;              // squared length width
  localparam int RTW  = RADW / 2;            // length width
  localparam int SPW  = 31;                  // speed width
  localparam int S3W  = SPW + 4;             // (level+1)*mass*3
  localparam int NUMW = RTW + FRAC_BITS + 1; // d << (FRAC_BITS+1)
  localparam int CW   = S3W + SPW;
  localparam logic [RADW-1:0] ONE_SQ = RADW'(1) << (2 * FRAC_BITS);

  typedef struct packed {
    logic [2:0][OW-1:0] off;
    logic [2:0][VW-1:0] vel;
    logic [SPW-1:0]     max_speed;
    logic [S3W-1:0]     s3;
    logic               at;
  } agent_t;

  function automatic logic [OW-1:0] mag_f(input logic [OW-1:0] v);
    mag_f = v[OW-1] ? (~v + OW'(1)) : v;
  endfunction

endpackage

// ===== rtl/asf_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, agent payload alongside.
// Depends on asf_pkg.
module asf_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [asf_pkg::RADW-1:0]   rad_i,
  input  asf_pkg::agent_t            agent_i,
  output logic                       valid_o,
  output logic [asf_pkg::RTW-1:0]    root_o,
  output asf_pkg::agent_t            agent_o
);
  import asf_pkg::*;

  localparam int REMW = RTW + 3;

  logic            vld_q  [RTW+1];
  logic [RADW-1:0] rad_q  [RTW+1];
  logic [REMW-1:0] rem_q  [RTW+1];
  logic [RTW-1:0]  root_q [RTW+1];
  agent_t          ag_q   [RTW+1];

  assign vld_q[0]  = valid_i;
  assign rad_q[0]  = rad_i;
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign ag_q[0]   = agent_i;

  for (genvar k = 0; k < RTW; k++) begin : g_stage
    logic [REMW-1:0] rem_n;
    logic [REMW-1:0] trial;
    logic            ge;
    always_comb begin
      rem_n = {rem_q[k][REMW-3:0], rad_q[k][RADW-1:RADW-2]};
      trial = {1'b0, root_q[k], 2'b01};
      ge    = rem_n >= trial;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      rad_q[k+1]  <= rad_q[k] << 2;
      rem_q[k+1]  <= ge ? rem_n - trial : rem_n;
      root_q[k+1] <= {root_q[k][RTW-2:0], ge};
      ag_q[k+1]   <= ag_q[k];
    end
  end

  assign valid_o = vld_q[RTW];
  assign root_o  = root_q[RTW];
  assign agent_o = ag_q[RTW];

endmodule

// ===== rtl/arrive_steering_force.sv =====
// Top level of the arrive steering force pipeline.
// Depends on asf_pkg, asf_sqrt and assert_macros.svh.
//
// Usage: drive one agent on the input ports and pulse start; the item is
// taken at any edge with start high, busy is always low, so a new agent may
// enter every cycle. Each result appears on force_*_o / at_target_o for one
// cycle with done_o high, in order. The pipeline stages are three for offset,
// square and sum, 33 for the bit-serial square root, 31 for the speed
// quotient, one for the speed limit, one for the three multipliers, 31 for
// the per-axis quotients, one output.
// Throughput is one agent per cycle. There is no backpressure: the receiver
// must take each result in its done_o cycle.
// cfg_we_i / cfg_wdata_i write the deceleration level (reset value 1);
// write it only while no agent is in flight.
// Reset clears all valid bits and sets the level back to 1; items in flight drop.
module arrive_steering_force (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_wdata_i,
  input  logic signed [31:0]  dest_x_i,
  input  logic signed [31:0]  dest_y_i,
  input  logic signed [31:0]  dest_z_i,
  input  logic signed [31:0]  pos_x_i,
  input  logic signed [31:0]  pos_y_i,
  input  logic signed [31:0]  pos_z_i,
  input  logic signed [31:0]  vel_x_i,
  input  logic signed [31:0]  vel_y_i,
  input  logic signed [31:0]  vel_z_i,
  input  logic [30:0]         max_speed_i,
  input  logic [30:0]         mass_i,
  output logic                done_o,
  output logic signed [31:0]  force_x_o,
  output logic signed [31:0]  force_y_o,
  output logic signed [31:0]  force_z_o,
  output logic                at_target_o
);
  import asf_pkg::*;

  localparam int LAT = 6 + RTW + 2 * SPW;

  logic [1:0] level_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= 2'd1;
    end else if (cfg_we_i) begin
      level_q <= cfg_wdata_i;
    end
  end

  assign busy = 1'b0;

  // stage 1: offsets and slowing scale
  logic   v1_q;
  agent_t a1_d, a1_q;
  logic [3:0] lvl3;
  always_comb begin
    lvl3 = (4'(level_q) + 4'd1) * 4'd3;
    a1_d.off[0]   = {dest_x_i[31], dest_x_i} - {pos_x_i[31], pos_x_i};
    a1_d.off[1]   = {dest_y_i[31], dest_y_i} - {pos_y_i[31], pos_y_i};
    a1_d.off[2]   = {dest_z_i[31], dest_z_i} - {pos_z_i[31], pos_z_i};
    a1_d.vel[0]   = vel_x_i;
    a1_d.vel[1]   = vel_y_i;
    a1_d.vel[2]   = vel_z_i;
    a1_d.max_speed = max_speed_i;
    a1_d.s3       = S3W'(mass_i) * S3W'(lvl3);
    a1_d.at       = 1'b0;
  end

  // stage 2: squares; stage 3: sum and target test
  logic   v2_q, v3_q;
  agent_t a2_q, a3_d, a3_q;
  logic [2:0][RADW-1:0] sq_q;
  logic [RADW-1:0] sum_d, sum_q;

  always_comb begin
    sum_d   = sq_q[0] + sq_q[1] + sq_q[2];
    a3_d    = a2_q;
    a3_d.at = sum_d <= ONE_SQ;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start && !busy;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q <= a1_d;
    a2_q <= a1_q;
    for (int i = 0; i < 3; i++) begin
      sq_q[i] <= RADW'(mag_f(a1_q.off[i])) * RADW'(mag_f(a1_q.off[i]));
    end
    sum_q   <= sum_d;
    a3_q    <= a3_d;
  end

  logic            sr_vld;
  logic [RTW-1:0]  sr_root;
  agent_t          sr_ag;

  asf_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .rad_i   (sum_q),
    .agent_i (a3_q),
    .valid_o (sr_vld),
    .root_o  (sr_root),
    .agent_o (sr_ag)
  );

  // speed quotient: (d << (FRAC_BITS+1)) / s3, one bit a stage
  logic            sv_q   [SPW+1];
  agent_t          sag_q  [SPW+1];
  logic [RTW-1:0]  sd_q   [SPW+1];
  logic [S3W:0]    srem_q [SPW+1];
  logic [SPW-1:0]  snlo_q [SPW+1];
  logic [SPW-1:0]  sqo_q  [SPW+1];
  logic            ssat_q [SPW+1];
  logic [NUMW-1:0] num0;

  assign num0      = {sr_root, (FRAC_BITS + 1)'(0)};
  assign sv_q[0]   = sr_vld;
  assign sag_q[0]  = sr_ag;
  assign sd_q[0]   = sr_root;
  assign srem_q[0] = (S3W + 1)'(num0 >> SPW);
  assign snlo_q[0] = num0[SPW-1:0];
  assign sqo_q[0]  = '0;
  // quotient would reach 2^SPW, or divisor zero: speed is the limit
  assign ssat_q[0] = (sr_ag.s3 == '0) || (CW'(num0) >= {sr_ag.s3, SPW'(0)});

  for (genvar k = 0; k < SPW; k++) begin : g_spd
    logic [S3W:0] rem_n;
    logic         ge;
    always_comb begin
      rem_n = {srem_q[k][S3W-1:0], snlo_q[k][SPW-1]};
      ge    = rem_n >= {1'b0, sag_q[k].s3};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[k+1] <= 1'b0;
      end else begin
        sv_q[k+1] <= sv_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      sag_q[k+1]  <= sag_q[k];
      sd_q[k+1]   <= sd_q[k];
      srem_q[k+1] <= ge ? rem_n - {1'b0, sag_q[k].s3} : rem_n;
      snlo_q[k+1] <= snlo_q[k] << 1;
      sqo_q[k+1]  <= {sqo_q[k][SPW-2:0], ge};
      ssat_q[k+1] <= ssat_q[k];
    end
  end

  // speed limit stage
  logic           spd_vld_q;
  logic [SPW-1:0] spd_q;
  agent_t         spd_ag_q;
  logic [RTW-1:0] spd_d_q;
  logic [SPW-1:0] spd_lim;

  always_comb begin
    if (ssat_q[SPW] || sqo_q[SPW] > sag_q[SPW].max_speed) begin
      spd_lim = sag_q[SPW].max_speed;
    end else begin
      spd_lim = sqo_q[SPW];
    end
  end

  // product stage: |off| * speed per axis
  localparam int PW = OW + SPW;
  logic           mv_q;
  agent_t         mag_q;
  logic [RTW-1:0] md_q;
  logic [2:0][PW-1:0] prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spd_vld_q <= 1'b0;
      mv_q      <= 1'b0;
    end else begin
      spd_vld_q <= sv_q[SPW];
      mv_q      <= spd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    spd_q    <= spd_lim;
    spd_ag_q <= sag_q[SPW];
    spd_d_q  <= sd_q[SPW];
    mag_q    <= spd_ag_q;
    md_q     <= spd_d_q;
    for (int i = 0; i < 3; i++) begin
      prod_q[i] <= PW'(mag_f(spd_ag_q.off[i])) * PW'(spd_q);
    end
  end

  // per-axis quotient: product / d, three lanes, one bit a stage
  logic                  lv_q   [SPW+1];
  agent_t                lag_q  [SPW+1];
  logic [RTW-1:0]        ld_q   [SPW+1];
  logic [2:0][RTW:0]     lrem_q [SPW+1];
  logic [2:0][SPW-1:0]   lplo_q [SPW+1];
  logic [2:0][SPW-1:0]   lqo_q  [SPW+1];

  assign lv_q[0]  = mv_q;
  assign lag_q[0] = mag_q;
  assign ld_q[0]  = md_q;
  for (genvar i = 0; i < 3; i++) begin : g_init
    assign lrem_q[0][i] = (RTW + 1)'(prod_q[i] >> SPW);
    assign lplo_q[0][i] = prod_q[i][SPW-1:0];
    assign lqo_q[0][i]  = '0;
  end

  for (genvar k = 0; k < SPW; k++) begin : g_lane
    logic [2:0][RTW:0] rem_n;
    logic [2:0]        ge;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rem_n[i] = {lrem_q[k][i][RTW-1:0], lplo_q[k][i][SPW-1]};
        ge[i]    = rem_n[i] >= {1'b0, ld_q[k]};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        lv_q[k+1] <= 1'b0;
      end else begin
        lv_q[k+1] <= lv_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      lag_q[k+1] <= lag_q[k];
      ld_q[k+1]  <= ld_q[k];
      for (int i = 0; i < 3; i++) begin
        lrem_q[k+1][i] <= ge[i] ? rem_n[i] - {1'b0, ld_q[k]} : rem_n[i];
        lplo_q[k+1][i] <= lplo_q[k][i] << 1;
        lqo_q[k+1][i]  <= {lqo_q[k][i][SPW-2:0], ge[i]};
      end
    end
  end

  // output stage: sign, subtract velocity, saturate, zero when at target
  logic [2:0][VW-1:0] frc_d, frc_q;
  logic               done_q, at_q;
  logic [VW+1:0]      des, dif;

  always_comb begin
    des = '0;
    dif = '0;
    for (int i = 0; i < 3; i++) begin
      des = lag_q[SPW].off[i][OW-1] ? -(VW + 2)'(lqo_q[SPW][i]) : (VW + 2)'(lqo_q[SPW][i]);
      dif = des - {{2{lag_q[SPW].vel[i][VW-1]}}, lag_q[SPW].vel[i]};
      if (lag_q[SPW].at) begin
        frc_d[i] = '0;
      end else if (!dif[VW+1] && dif[VW:VW-1] != 2'b00) begin
        frc_d[i] = {1'b0, {(VW - 1){1'b1}}};
      end else if (dif[VW+1] && dif[VW:VW-1] != 2'b11) begin
        frc_d[i] = {1'b1, {(VW - 1){1'b0}}};
      end else begin
        frc_d[i] = dif[VW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= lv_q[SPW];
    end
  end

  always_ff @(posedge clk_i) begin
    frc_q <= frc_d;
    at_q  <= lag_q[SPW].at;
  end

  assign done_o      = done_q;
  assign force_x_o   = frc_q[0];
  assign force_y_o   = frc_q[1];
  assign force_z_o   = frc_q[2];
  assign at_target_o = at_q;

`include "assert_macros.svh"

  `ASSERT_CLK(a_latency, clk_i, rst_ni, (start && !busy) |-> ##LAT done_o)
  `ASSERT_CLK(a_at_zero, clk_i, rst_ni, (done_o && at_target_o) |-> (frc_q == '0))
  `ASSERT_CLK(a_spd_lim, clk_i, rst_ni, spd_vld_q |-> (spd_q <= spd_ag_q.max_speed))
  `ASSERT_NEVER(a_busy, clk_i, rst_ni, busy)

endmodule
